/* rtl/tqi_pkg.sv */
// Shared types and constants for the table quadratic interpolator.
// No dependencies.
package tqi_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 256;
    // Q scales of numerator and denominator cancel, so the datapath never
    // needs the fraction width; it is fixed here for the whole block.
    localparam int FRAC_BITS           = 16;
    localparam int DATA_W              = 32;
    localparam int INDEX_W             = 8;
    localparam int COUNT_W             = 9;
    localparam int COUNT_RESET         = 4;
    localparam int MIN_COUNT           = 4;

    // Difference of two 32-bit values: 33 bits; product of two magnitudes fits 64 bits
    localparam int DIFF_W = 33;
    localparam int PROD_W = 64;
    localparam int NUM_W  = 96;
    localparam int SUM_W  = 100;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_SATURATED = 2'd1,
        STATUS_DIV_ZERO  = 2'd2
    } status_t;

    // Request to the shared multiply/divide unit
    typedef struct packed {
        logic              start;
        logic              is_div;
        logic [NUM_W-1:0]  op_a;
        logic [PROD_W-1:0] op_b;
    } alu_req_t;

    typedef struct packed {
        logic              done;
        logic [NUM_W-1:0]  result;
    } alu_rsp_t;

endpackage

/* rtl/tqi_alu.sv */
// Shared bit-serial arithmetic unit: unsigned multiply and rounded divide.
// Depends on tqi_pkg.
module tqi_alu
    import tqi_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  alu_req_t req,
    output alu_rsp_t rsp
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic              busy_reg, busy_next;
    logic              div_reg, div_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [NUM_W-1:0]  a_reg, a_next;      // multiplicand shifting left / dividend
    logic [PROD_W-1:0] b_reg, b_next;      // multiplier shifting right / divisor
    logic [NUM_W-1:0]  acc_reg, acc_next;  // product / quotient
    logic [PROD_W:0]   rem_reg, rem_next;
    logic              done_reg, done_next;

    logic [PROD_W:0]   rem_sh;
    logic [PROD_W:0]   rem_dif;
    logic [PROD_W:0]   half_chk;

    always_comb
    begin
        busy_next = busy_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        done_next = 1'b0;
        rem_sh    = {rem_reg[PROD_W-1:0], a_reg[NUM_W-1]};
        rem_dif   = rem_sh - {1'b0, b_reg};
        half_chk  = {1'b0, b_reg} - rem_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            div_next  = req.is_div;
            cnt_next  = CNT_W'(req.is_div ? NUM_W : PROD_W);
            a_next    = req.op_a;
            b_next    = req.op_b;
            acc_next  = '0;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                // Round to nearest, ties up
                if (div_reg && (rem_reg >= half_chk))
                    acc_next = acc_reg + NUM_W'(1);
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - CNT_W'(1);
                if (div_reg)
                begin
                    a_next = {a_reg[NUM_W-2:0], 1'b0};
                    if (!rem_dif[PROD_W])
                    begin
                        rem_next = rem_dif;
                        acc_next = {acc_reg[NUM_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next = rem_sh;
                        acc_next = {acc_reg[NUM_W-2:0], 1'b0};
                    end
                end
                else
                begin
                    if (b_reg[0])
                        acc_next = acc_reg + a_reg;
                    a_next = {a_reg[NUM_W-2:0], 1'b0};
                    b_next = {1'b0, b_reg[PROD_W-1:1]};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            div_reg  <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            div_reg  <= div_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
        rem_reg <= rem_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.result = acc_reg;

endmodule

/* rtl/table_quadratic_interpolator.sv */
// Top level of the table quadratic interpolator: table memory, bisection
// sequencer and Lagrange evaluation. Depends on tqi_pkg and tqi_alu.
//
// Usage:
//   s_axis carries requests: tdata = {y_value, x_value, point_index, operation}
//   packed from bit 0 up, 73 bits padded to 80. A write request (operation 0)
//   stores one point at its accepting edge and gives no result; writes can
//   follow back to back. A query request (operation 1) bisects the first
//   point_count entries, one registered table read per step (8 steps for
//   256 points), reads its three points, then forms three Lagrange terms on
//   one shared bit-serial unit. Each term takes three 64-step multiplies and
//   one 96-step rounded divide, then an accumulate.
//   m_axis carries {status, interpolated_value} in 34 bits padded to 40.
//   The result sits in an output register; the block takes no new request
//   until the receiver has taken it, and it holds steady under stall.
//   point_count must be written through cfg_wen/cfg_wdata only while idle
//   (the block does not check); it is clamped to [4, TABLE_DEPTH] internally.
//   Reset clears control state and sets point_count to 4; the table holds
//   no valid data until written and needs no clearing pass.
module table_quadratic_interpolator
    import tqi_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wen,
    input  logic [8:0]   cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [0] operation, [8:1] point_index, [40:9] x_value, [72:41] y_value
    input  logic [79:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [31:0] interpolated_value, [33:32] status
    output logic [39:0]  m_axis_tdata
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [11:0] {
        S_IDLE  = 12'b000000000001,
        S_BIS   = 12'b000000000010,
        S_BWAIT = 12'b000000000100,
        S_RD    = 12'b000000001000,
        S_RWAIT = 12'b000000010000,
        S_CHK   = 12'b000000100000,
        S_MUL1  = 12'b000001000000,
        S_MUL2  = 12'b000010000000,
        S_DMUL  = 12'b000100000000,
        S_DIV   = 12'b001000000000,
        S_ACC   = 12'b010000000000,
        S_OUT   = 12'b100000000000
    } state_t;

    state_t state_reg, state_next;

    logic [DATA_W-1:0] xmem [TABLE_DEPTH];
    logic [DATA_W-1:0] ymem [TABLE_DEPTH];
    logic [AW-1:0]     raddr;
    logic [DATA_W-1:0] xr_reg, yr_reg;

    logic [COUNT_W-1:0] cnt_cfg_reg;
    logic [CW-1:0]      n_use;

    logic              op_in;
    logic [INDEX_W-1:0] idx_in;
    logic [DATA_W-1:0] x_in, y_in;

    logic [CW-1:0] lo_reg, lo_next, hi_reg, hi_next, mid;
    logic signed [DATA_W-1:0] x0_reg, x0_next;
    logic signed [DATA_W-1:0] px_reg [3];
    logic signed [DATA_W-1:0] py_reg [3];
    logic [1:0] rk_reg, rk_next;        // point being read
    logic [1:0] tk_reg, tk_next;        // term being evaluated
    logic [CW-1:0] p_idx [3];

    logic neg_reg, neg_next;
    logic [NUM_W-1:0]  num_reg, num_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [DATA_W-1:0] res_reg, res_next;
    status_t st_reg, st_next;
    logic ovalid_reg, ovalid_next;

    alu_req_t areq;
    alu_rsp_t arsp;

    logic [1:0] ob, oc;
    logic signed [DIFF_W-1:0] d_n1, d_n2, d_d1, d_d2;
    logic [DIFF_W-1:0] m_n1, m_n2, m_d1, m_d2;
    logic [DATA_W-1:0] m_f;
    logic sgn_term;

    assign op_in  = s_axis_tdata[0];
    assign idx_in = s_axis_tdata[8:1];
    assign x_in   = s_axis_tdata[40:9];
    assign y_in   = s_axis_tdata[72:41];

    assign s_axis_tready = (state_reg == S_IDLE) && !ovalid_reg;
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = {6'd0, st_reg, res_reg};

    // Clamp the configured count to the usable range
    always_comb
    begin
        if (cnt_cfg_reg < COUNT_W'(MIN_COUNT))
            n_use = CW'(MIN_COUNT);
        else if (32'(cnt_cfg_reg) > TABLE_DEPTH)
            n_use = CW'(TABLE_DEPTH);
        else
            n_use = CW'(cnt_cfg_reg);
    end

    assign mid = CW'(({1'b0, lo_reg} + {1'b0, hi_reg}) >> 1);

    // Bracketing index and its two partners
    always_comb
    begin
        p_idx[0] = lo_reg;
        if (lo_reg < n_use - CW'(2))
        begin
            p_idx[1] = lo_reg + CW'(1);
            p_idx[2] = lo_reg + CW'(2);
        end
        else
        begin
            p_idx[1] = lo_reg - CW'(1);
            p_idx[2] = lo_reg - CW'(2);
        end
    end

    assign raddr = (state_reg == S_RD) ? AW'(p_idx[rk_reg]) : AW'(mid);

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready && op_in == OP_WRITE
            && 32'(idx_in) < TABLE_DEPTH)
        begin
            xmem[AW'(idx_in)] <= x_in;
            ymem[AW'(idx_in)] <= y_in;
        end
        xr_reg <= xmem[raddr];
        yr_reg <= ymem[raddr];
    end

    // Term operands: the other two points of term tk
    always_comb
    begin
        unique case (tk_reg)
            2'd0:    begin ob = 2'd1; oc = 2'd2; end
            2'd1:    begin ob = 2'd0; oc = 2'd2; end
            default: begin ob = 2'd0; oc = 2'd1; end
        endcase
        d_n1 = DIFF_W'(x0_reg) - DIFF_W'(px_reg[ob]);
        d_n2 = DIFF_W'(x0_reg) - DIFF_W'(px_reg[oc]);
        d_d1 = DIFF_W'(px_reg[tk_reg]) - DIFF_W'(px_reg[ob]);
        d_d2 = DIFF_W'(px_reg[tk_reg]) - DIFF_W'(px_reg[oc]);
        m_n1 = d_n1[DIFF_W-1] ? DIFF_W'(-d_n1) : DIFF_W'(d_n1);
        m_n2 = d_n2[DIFF_W-1] ? DIFF_W'(-d_n2) : DIFF_W'(d_n2);
        m_d1 = d_d1[DIFF_W-1] ? DIFF_W'(-d_d1) : DIFF_W'(d_d1);
        m_d2 = d_d2[DIFF_W-1] ? DIFF_W'(-d_d2) : DIFF_W'(d_d2);
        m_f  = py_reg[tk_reg][DATA_W-1] ? DATA_W'(-py_reg[tk_reg])
                                        : DATA_W'(py_reg[tk_reg]);
        sgn_term = d_n1[DIFF_W-1] ^ d_n2[DIFF_W-1] ^ d_d1[DIFF_W-1]
                 ^ d_d2[DIFF_W-1] ^ py_reg[tk_reg][DATA_W-1];
    end

    tqi_alu u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (areq),
        .rsp   (arsp)
    );

    always_comb
    begin
        state_next  = state_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        x0_next     = x0_reg;
        rk_next     = rk_reg;
        tk_next     = tk_reg;
        neg_next    = neg_reg;
        num_next    = num_reg;
        sum_next    = sum_reg;
        res_next    = res_reg;
        st_next     = st_reg;
        ovalid_next = ovalid_reg;
        areq        = '0;
        if (ovalid_reg && m_axis_tready)
            ovalid_next = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid && s_axis_tready && op_in == OP_QUERY)
                begin
                    x0_next    = $signed(x_in);
                    lo_next    = '0;
                    hi_next    = n_use - CW'(1);
                    tk_next    = 2'd0;
                    sum_next   = '0;
                    state_next = S_BIS;
                end
            end
            S_BIS:
            begin
                // Address mid presented this cycle; data next
                if (hi_reg - lo_reg > CW'(1))
                    state_next = S_BWAIT;
                else
                begin
                    rk_next    = 2'd0;
                    state_next = S_RD;
                end
            end
            S_BWAIT:
            begin
                if (x0_reg >= $signed(xr_reg))
                    lo_next = mid;
                else
                    hi_next = mid;
                state_next = S_BIS;
            end
            S_RD:
            begin
                state_next = S_RWAIT;
            end
            S_RWAIT:
            begin
                rk_next = rk_reg + 2'd1;
                if (rk_reg == 2'd2)
                    state_next = S_CHK;
                else
                    state_next = S_RD;
            end
            S_CHK:
            begin
                // Entered once per term; equal x: div-zero, else first multiply
                if (px_reg[0] == px_reg[1] || px_reg[0] == px_reg[2]
                    || px_reg[1] == px_reg[2])
                begin
                    res_next    = '0;
                    st_next     = STATUS_DIV_ZERO;
                    ovalid_next = 1'b1;
                    state_next  = S_OUT;
                end
                else
                begin
                    areq.start = 1'b1;
                    areq.op_a  = NUM_W'(m_n1);
                    areq.op_b  = PROD_W'(m_n2);
                    state_next = S_MUL1;
                end
            end
            S_MUL1:
            begin
                if (arsp.done)
                begin
                    // Product of two diffs fits in 64 bits
                    neg_next   = sgn_term;
                    areq.start = 1'b1;
                    areq.op_a  = NUM_W'(m_f);
                    areq.op_b  = arsp.result[PROD_W-1:0];
                    state_next = S_MUL2;
                end
            end
            S_MUL2:
            begin
                if (arsp.done)
                begin
                    num_next   = arsp.result;
                    areq.start = 1'b1;
                    areq.op_a  = NUM_W'(m_d1);
                    areq.op_b  = PROD_W'(m_d2);
                    state_next = S_DMUL;
                end
            end
            S_DMUL:
            begin
                if (arsp.done)
                begin
                    areq.start = 1'b1;
                    areq.is_div = 1'b1;
                    areq.op_a  = num_reg;
                    areq.op_b  = arsp.result[PROD_W-1:0];
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (arsp.done)
                begin
                    if (neg_reg)
                        sum_next = sum_reg - SUM_W'(arsp.result);
                    else
                        sum_next = sum_reg + SUM_W'(arsp.result);
                    state_next = S_ACC;
                end
            end
            S_ACC:
            begin
                if (tk_reg == 2'd2)
                begin
                    // Saturate the exact sum to 32 bits
                    if (sum_reg > SUM_W'(signed'(32'h7FFFFFFF)))
                    begin
                        res_next = 32'h7FFFFFFF;
                        st_next  = STATUS_SATURATED;
                    end
                    else if (sum_reg < -SUM_W'(64'sh80000000))
                    begin
                        res_next = 32'h80000000;
                        st_next  = STATUS_SATURATED;
                    end
                    else
                    begin
                        res_next = sum_reg[DATA_W-1:0];
                        st_next  = STATUS_OK;
                    end
                    ovalid_next = 1'b1;
                    state_next  = S_OUT;
                end
                else
                begin
                    // Advance to the next term
                    tk_next    = tk_reg + 2'd1;
                    state_next = S_CHK;
                end
            end
            S_OUT:
            begin
                // Hold until the result is taken
                if (!ovalid_next)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            ovalid_reg  <= 1'b0;
            cnt_cfg_reg <= COUNT_W'(COUNT_RESET);
            lo_reg      <= '0;
            hi_reg      <= '0;
            rk_reg      <= '0;
            tk_reg      <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
            lo_reg     <= lo_next;
            hi_reg     <= hi_next;
            rk_reg     <= rk_next;
            tk_reg     <= tk_next;
            if (cfg_wen)
                cnt_cfg_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        x0_reg  <= x0_next;
        neg_reg <= neg_next;
        num_reg <= num_next;
        res_reg <= res_next;
        st_reg  <= st_next;
        sum_reg <= sum_next;
        if (state_reg == S_RWAIT)
        begin
            px_reg[rk_reg] <= $signed(xr_reg);
            py_reg[rk_reg] <= $signed(yr_reg);
        end
    end

`ifndef NO_ASSERTIONS
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> (state_reg == S_IDLE))
        else $error("request accepted while busy");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("result changed under stall");
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (st_reg == STATUS_OK || st_reg == STATUS_SATURATED
                           || st_reg == STATUS_DIV_ZERO))
        else $error("bad status code");
`endif

endmodule
